>>> hdl/plt_pkg.sv
package plt_pkg;

	localparam int PEER_SLOTS = 4;
	localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int MAC_W      = 48;
	localparam int DATA_W     = 32;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [DATA_W-1:0] READY_CODE  = 32'd666;
	localparam logic [DATA_W-1:0] KEEP_CODE   = 32'd0;
	localparam logic [TIME_W-1:0] DEF_TIMEOUT = 32'd6000;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN = 1'b1;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		ACT_PAIR   = 2'd0,
		ACT_STATUS = 2'd1,
		ACT_KEEP   = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_NOFREE  = 2'd2,
		ST_READY   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_FIND,
		S_APPLY,
		S_CHECK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              ready;
		logic              online;
		logic [MAC_W-1:0]  addr;
		logic [TIME_W-1:0] last_seen;
	} plt_rd_t;

	typedef struct packed {
		logic              ins;
		logic              set_ready;
		logic              set_online;
		logic              stamp;
		logic              drop;
		slot_idx_t         idx;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] stamp_time;
	} plt_wr_t;

	typedef struct packed {
		status_t    status;
		logic [1:0] slot;
		logic       reply;
		logic [3:0] lost;
		logic       done;
	} plt_res_t;

endpackage

>>> hdl/plt_table.sv
module plt_table (
	input  logic              clk,
	input  logic              arst_n,
	input  plt_pkg::slot_idx_t rd_idx,
	output plt_pkg::plt_rd_t  rd,
	output logic              all_ready,
	input  plt_pkg::plt_wr_t  wr
);

	logic [plt_pkg::MAC_W-1:0]  addr_q [plt_pkg::PEER_SLOTS];
	logic [plt_pkg::TIME_W-1:0] seen_q [plt_pkg::PEER_SLOTS];
	logic [plt_pkg::PEER_SLOTS-1:0] valid_q;
	logic [plt_pkg::PEER_SLOTS-1:0] ready_q;
	logic [plt_pkg::PEER_SLOTS-1:0] online_q;

	always_comb begin
		rd.valid     = valid_q[rd_idx];
		rd.ready     = ready_q[rd_idx];
		rd.online    = online_q[rd_idx];
		rd.addr      = addr_q[rd_idx];
		rd.last_seen = seen_q[rd_idx];
		all_ready    = &(valid_q & ready_q);
	end

	always_ff @(posedge clk) begin
		if (wr.ins) begin
			addr_q[wr.idx] <= wr.mac;
		end
		if (wr.stamp) begin
			seen_q[wr.idx] <= wr.stamp_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ready_q  <= '0;
			online_q <= '0;
		end else begin
			if (wr.ins) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (wr.set_ready) begin
				ready_q[wr.idx] <= 1'b1;
			end
			if (wr.set_online) begin
				online_q[wr.idx] <= 1'b1;
			end
			if (wr.drop) begin
				ready_q[wr.idx]  <= 1'b0;
				online_q[wr.idx] <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/plt_ctrl.sv
module plt_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic [plt_pkg::MAC_W-1:0]       peer_mac,
	input  logic [plt_pkg::DATA_W-1:0]      event_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output plt_pkg::slot_idx_t              rd_idx,
	input  plt_pkg::plt_rd_t                rd,
	input  logic                            all_ready,
	output plt_pkg::plt_wr_t                wr,
	output logic                            res_valid,
	input  logic                            res_take,
	output plt_pkg::plt_res_t               res
);

	plt_pkg::state_t    state_q, state_d;
	plt_pkg::action_t   act_q;
	logic [plt_pkg::MAC_W-1:0]  mac_q;
	plt_pkg::slot_idx_t cnt_q;
	logic               hit_q, free_q;
	plt_pkg::slot_idx_t hit_idx_q, free_idx_q;
	plt_pkg::plt_res_t  res_q, res_d;
	logic [plt_pkg::TIME_W-1:0] time_q;
	logic [plt_pkg::TIME_W-1:0] timeout_q;
	logic               open_q;
	logic               shut_q;

	plt_pkg::action_t   in_act;
	plt_pkg::slot_idx_t sel_idx;
	logic               sel_ok;
	logic               last;
	logic               match;
	logic               expired;
	logic               reject;
	logic               close;

	assign cfg_ready = 1'b1;
	assign res       = res_q;
	assign in_act    = plt_pkg::action_t'(action);
	assign sel_idx   = hit_q ? hit_idx_q : free_idx_q;
	assign sel_ok    = hit_q | free_q;
	assign last      = (cnt_q == plt_pkg::SLOT_W'(plt_pkg::PEER_SLOTS - 1));
	assign match     = rd.valid && (rd.addr == mac_q);
	assign expired   = rd.valid && rd.online && ((time_q - rd.last_seen) >= timeout_q);

	always_comb begin
		unique case (in_act)
			plt_pkg::ACT_PAIR:   reject = !open_q;
			plt_pkg::ACT_STATUS: reject = !open_q || (event_data != plt_pkg::READY_CODE);
			plt_pkg::ACT_KEEP:   reject = (event_data != plt_pkg::KEEP_CODE);
			plt_pkg::ACT_TICK:   reject = 1'b0;
			default:             reject = 1'b1;
		endcase
		reject = reject || shut_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		res_d         = res_q;
		in_stall      = 1'b1;
		res_valid     = 1'b0;
		close         = 1'b0;
		rd_idx        = (state_q == plt_pkg::S_APPLY) ? sel_idx : cnt_q;
		wr            = '0;
		wr.idx        = rd_idx;
		wr.mac        = mac_q;
		wr.stamp_time = time_q;
		unique case (state_q)
			plt_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					res_d = '0;
					if (reject) begin
						res_d.status = plt_pkg::ST_IGNORED;
						state_d      = plt_pkg::S_DONE;
					end else if (in_act == plt_pkg::ACT_TICK) begin
						state_d = plt_pkg::S_TICK;
					end else begin
						state_d = plt_pkg::S_FIND;
					end
				end
			end
			plt_pkg::S_TICK: begin
				if (expired) begin
					wr.drop    = 1'b1;
					res_d.lost = res_q.lost | (4'b0001 << cnt_q);
				end
				if (last) begin
					state_d = plt_pkg::S_DONE;
				end
			end
			plt_pkg::S_FIND: begin
				if (last) begin
					state_d = plt_pkg::S_APPLY;
				end
			end
			plt_pkg::S_APPLY: begin
				state_d = plt_pkg::S_DONE;
				if (act_q != plt_pkg::ACT_STATUS) begin
					res_d.reply = 1'b1;
				end
				if (!sel_ok) begin
					res_d.status = plt_pkg::ST_NOFREE;
				end else begin
					res_d.slot = 2'(sel_idx);
					unique case (act_q)
						plt_pkg::ACT_STATUS: begin
							if (hit_q && rd.ready) begin
								res_d.status = plt_pkg::ST_READY;
							end else begin
								wr.ins       = !hit_q;
								wr.set_ready = 1'b1;
								state_d      = plt_pkg::S_CHECK;
							end
						end
						plt_pkg::ACT_KEEP: begin
							wr.ins        = !hit_q;
							wr.set_ready  = 1'b1;
							wr.set_online = 1'b1;
							wr.stamp      = 1'b1;
						end
						default: begin
							wr.ins = !hit_q;
						end
					endcase
				end
			end
			plt_pkg::S_CHECK: begin
				if (all_ready) begin
					res_d.done = 1'b1;
					close      = 1'b1;
				end
				state_d = plt_pkg::S_DONE;
			end
			plt_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = plt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = plt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == plt_pkg::S_IDLE) begin
			cnt_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			act_q  <= in_act;
			mac_q  <= peer_mac;
		end else if (state_q == plt_pkg::S_TICK || state_q == plt_pkg::S_FIND) begin
			cnt_q <= cnt_q + 1'b1;
			if (state_q == plt_pkg::S_FIND) begin
				if (match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cnt_q;
				end
				if (!rd.valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= cnt_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			open_q    <= 1'b1;
			timeout_q <= plt_pkg::DEF_TIMEOUT;
			shut_q    <= 1'b0;
		end else begin
			if (state_q == plt_pkg::S_IDLE && in_valid && in_act == plt_pkg::ACT_TICK) begin
				time_q <= time_q + 1'b1;
			end
			if (close) begin
				open_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					plt_pkg::CFG_TIMEOUT:  timeout_q <= cfg_data[plt_pkg::TIME_W-1:0];
					plt_pkg::CFG_SHUTDOWN: shut_q    <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> hdl/peer_liveness_table.sv
// channel  | handshake             | payload
// in       | in_valid / in_stall   | action, peer_mac, event_data
// out      | out_valid / out_stall | status, slot, send_reply, lost_mask, all_ready
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request at a time; the slot table is walked one slot per cycle through one
// address comparator and one elapsed-time subtract and compare
// rejected or shutdown requests go straight to the result; a tick walks every slot;
// pair and keepalive walk every slot, then apply; a status confirm may add a check step
// the result sits in an output register, so the next request is taken while it waits
// reset clears marks, time and registers at once; out_stall holds the result, and a
// second finished request then waits in the sequencer and stalls the input
module peer_liveness_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      action,
	input  logic [plt_pkg::MAC_W-1:0]       peer_mac,
	input  logic [plt_pkg::DATA_W-1:0]      event_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [1:0]                      slot,
	output logic                            send_reply,
	output logic [3:0]                      lost_mask,
	output logic                            all_ready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	plt_pkg::slot_idx_t rd_idx;
	plt_pkg::plt_rd_t   rd;
	plt_pkg::plt_wr_t   wr;
	plt_pkg::plt_res_t  res;
	logic               tbl_all_ready;
	logic               res_valid;
	logic               res_take;
	logic               out_valid_q;
	plt_pkg::plt_res_t  out_q;

	plt_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.rd        (rd),
		.all_ready (tbl_all_ready),
		.wr        (wr)
	);

	plt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.peer_mac   (peer_mac),
		.event_data (event_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rd_idx     (rd_idx),
		.rd         (rd),
		.all_ready  (tbl_all_ready),
		.wr         (wr),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign slot       = out_q.slot;
	assign send_reply = out_q.reply;
	assign lost_mask  = out_q.lost;
	assign all_ready  = out_q.done;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import plt_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;

	class liveness_scoreboard;
		logic [MAC_W-1:0]  addr [PEER_SLOTS];
		logic [TIME_W-1:0] seen [PEER_SLOTS];
		bit                used [PEER_SLOTS];
		bit                rdy  [PEER_SLOTS];
		bit                live [PEER_SLOTS];
		logic [TIME_W-1:0] t_now;
		logic [TIME_W-1:0] tmo;
		bit                pair_open;
		bit                halted;
		plt_res_t          outcome_q [$];
		int                errors;

		function new();
			for (int i = 0; i < PEER_SLOTS; i++) begin
				used[i] = 1'b0;
				rdy[i]  = 1'b0;
				live[i] = 1'b0;
			end
			t_now     = '0;
			tmo       = DEF_TIMEOUT;
			pair_open = 1'b1;
			halted    = 1'b0;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			if (idx == CFG_TIMEOUT)
				tmo = v;
			else
				halted = v[0];
		endfunction

		function int find_peer(logic [MAC_W-1:0] mac);
			for (int i = 0; i < PEER_SLOTS; i++)
				if (used[i] && addr[i] == mac)
					return i;
			return -1;
		endfunction

		function int free_slot();
			for (int i = 0; i < PEER_SLOTS; i++)
				if (!used[i])
					return i;
			return -1;
		endfunction

		function int claim(logic [MAC_W-1:0] mac);
			int idx;
			idx = find_peer(mac);
			if (idx < 0) begin
				idx = free_slot();
				if (idx >= 0) begin
					addr[idx] = mac;
					used[idx] = 1'b1;
				end
			end
			return idx;
		endfunction

		// would a ready confirm from this peer complete pairing
		function bit closes_pairing(logic [MAC_W-1:0] mac);
			int idx;
			int n;
			if (!pair_open || halted)
				return 1'b0;
			idx = find_peer(mac);
			if (idx < 0)
				idx = free_slot();
			if (idx < 0 || rdy[idx])
				return 1'b0;
			n = 1;
			for (int i = 0; i < PEER_SLOTS; i++)
				if (used[i] && rdy[i])
					n++;
			return (n >= PEER_SLOTS);
		endfunction

		function void note_request(action_t a, logic [MAC_W-1:0] mac, logic [DATA_W-1:0] d);
			plt_res_t          r;
			int                idx;
			int                n;
			logic [TIME_W-1:0] gap;
			r = '0;
			if (a == ACT_TICK) begin
				t_now = t_now + 1;
				if (halted) begin
					r.status = ST_IGNORED;
				end else begin
					for (int i = 0; i < PEER_SLOTS; i++) begin
						if (used[i] && live[i]) begin
							gap = t_now - seen[i];
							if (gap >= tmo) begin
								live[i] = 1'b0;
								rdy[i]  = 1'b0;
								if (i < 4)
									r.lost[i] = 1'b1;
							end
						end
					end
				end
			end else if (halted) begin
				r.status = ST_IGNORED;
			end else if (a == ACT_PAIR) begin
				if (!pair_open) begin
					r.status = ST_IGNORED;
				end else begin
					idx = claim(mac);
					r.reply = 1'b1;
					if (idx < 0)
						r.status = ST_NOFREE;
					else
						r.slot = idx[1:0];
				end
			end else if (a == ACT_STATUS) begin
				if (!pair_open || d != READY_CODE) begin
					r.status = ST_IGNORED;
				end else begin
					idx = claim(mac);
					if (idx < 0) begin
						r.status = ST_NOFREE;
					end else begin
						r.slot = idx[1:0];
						if (rdy[idx]) begin
							r.status = ST_READY;
						end else begin
							rdy[idx] = 1'b1;
							n = 0;
							for (int i = 0; i < PEER_SLOTS; i++)
								if (used[i] && rdy[i])
									n++;
							if (n >= PEER_SLOTS) begin
								pair_open = 1'b0;
								r.done    = 1'b1;
							end
						end
					end
				end
			end else begin
				if (d != KEEP_CODE) begin
					r.status = ST_IGNORED;
				end else begin
					idx = claim(mac);
					r.reply = 1'b1;
					if (idx < 0) begin
						r.status = ST_NOFREE;
					end else begin
						r.slot    = idx[1:0];
						seen[idx] = t_now;
						live[idx] = 1'b1;
						rdy[idx]  = 1'b1;
					end
				end
			end
			outcome_q.push_back(r);
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_result(logic [1:0] st, logic [1:0] sl, logic rp, logic [3:0] lm,
		                           logic ar);
			plt_res_t e;
			if (outcome_q.size() == 0) begin
				note_error($sformatf("result with no request outstanding, status %0d slot %0d",
				                     st, sl));
				return;
			end
			e = outcome_q.pop_front();
			if (st !== e.status)
				note_error($sformatf("status expected %0d got %0d", e.status, st));
			if (sl !== e.slot)
				note_error($sformatf("slot expected %0d got %0d", e.slot, sl));
			if (rp !== e.reply)
				note_error($sformatf("send_reply expected %0d got %0d", e.reply, rp));
			if (lm !== e.lost)
				note_error($sformatf("lost_mask expected %h got %h", e.lost, lm));
			if (ar !== e.done)
				note_error($sformatf("all_ready expected %0d got %0d", e.done, ar));
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            action;
	logic [MAC_W-1:0]      peer_mac;
	logic [DATA_W-1:0]     event_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [1:0]            slot;
	logic                  send_reply;
	logic [3:0]            lost_mask;
	logic                  all_ready;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	liveness_scoreboard sb;
	int                 snd_idle_pct;
	int                 rcv_idle_pct;
	bit                 hold_req  = 1'b0;
	int                 hold_left = 0;
	int                 cycle_cnt;
	logic [MAC_W-1:0]   tbl_mac   [4];
	logic [MAC_W-1:0]   spare_mac [4];

	peer_liveness_table u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[MAC_W-1:0];
	endfunction

	task automatic send_item(action_t a, logic [MAC_W-1:0] m, logic [DATA_W-1:0] d);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= a;
		peer_mac   <= m;
		event_data <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(a, m, d);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_DATA_W-1:0] tmo, bit sd);
		logic [CFG_DATA_W-1:0] w;
		w    = $urandom();
		w[0] = sd;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data  <= tmo;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(CFG_TIMEOUT, tmo);
		cfg_index <= CFG_SHUTDOWN;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(CFG_SHUTDOWN, w);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item(bit keep_open);
		int                r;
		int                pick;
		action_t           a;
		logic [MAC_W-1:0]  m;
		logic [DATA_W-1:0] d;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			a = action_t'($urandom_range(0, 3));
			m = rand_mac();
			d = $urandom();
		end else begin
			r = $urandom_range(0, 99);
			if (r < 30)
				a = ACT_TICK;
			else if (r < 60)
				a = ACT_KEEP;
			else if (r < 77)
				a = ACT_PAIR;
			else
				a = ACT_STATUS;
			pick = $urandom_range(0, 99);
			if (pick < 80)
				m = tbl_mac[$urandom_range(0, 3)];
			else if (pick < 95)
				m = spare_mac[$urandom_range(0, 3)];
			else
				m = rand_mac();
			d = $urandom();
			if (a == ACT_KEEP && $urandom_range(0, 9) != 0)
				d = KEEP_CODE;
			if (a == ACT_STATUS && $urandom_range(0, 99) < 85)
				d = READY_CODE;
		end
		// hold pairing open until the closing sequence
		if (keep_open && a == ACT_STATUS && d == READY_CODE && sb.closes_pairing(m))
			d = READY_CODE ^ (32'd1 << $urandom_range(0, 31));
		send_item(a, m, d);
	endtask

	// result side: check, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, slot, send_reply, lost_mask, all_ready);
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** peer_liveness_table: FAILED **");
		$finish;
	end

	initial begin
		int                    seg_len [8];
		logic [CFG_DATA_W-1:0] seg_tmo [8];
		bit                    seg_sd  [8];
		sb = new();
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_PAIR;
		peer_mac   <= '0;
		event_data <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_TIMEOUT;
		cfg_data   <= '0;
		snd_idle_pct = 20;
		rcv_idle_pct = 73;
		tbl_mac[0] = '0;
		tbl_mac[1] = '1;
		tbl_mac[2] = rand_mac();
		tbl_mac[3] = rand_mac();
		for (int k = 0; k < 4; k++)
			spare_mac[k] = rand_mac();
		seg_len = '{215, 215, 215, 215, 80, 215, 215, 215};
		seg_tmo = '{32'd3, 32'd1, 32'hFFFF_FFFF, 32'($urandom_range(2, 40)), 32'd5,
		            32'($urandom_range(2, 12)), 32'd4, 32'($urandom_range(1, 60))};
		seg_sd  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults from reset, fill the table, duplicates, full table
		send_item(ACT_TICK, rand_mac(), $urandom());
		send_item(ACT_KEEP, tbl_mac[2], $urandom() | 32'd1);
		send_item(ACT_STATUS, tbl_mac[0], READY_CODE + 32'd1);
		send_item(ACT_PAIR, tbl_mac[0], $urandom());
		send_item(ACT_PAIR, tbl_mac[0], $urandom());
		send_item(ACT_PAIR, tbl_mac[1], $urandom());
		send_item(ACT_STATUS, tbl_mac[0], READY_CODE);
		send_item(ACT_STATUS, tbl_mac[0], READY_CODE);
		send_item(ACT_KEEP, tbl_mac[2], KEEP_CODE);
		send_item(ACT_PAIR, tbl_mac[3], $urandom());
		send_item(ACT_PAIR, spare_mac[0], $urandom());
		send_item(ACT_STATUS, spare_mac[0], READY_CODE);
		send_item(ACT_KEEP, spare_mac[0], KEEP_CODE);
		send_item(ACT_TICK, rand_mac(), $urandom());
		settle();
		write_cfg(32'd2, 1'b0);
		send_item(ACT_TICK, rand_mac(), $urandom());
		send_item(ACT_TICK, rand_mac(), $urandom());
		settle();
		write_cfg(32'd2, 1'b1);
		send_item(ACT_PAIR, tbl_mac[0], $urandom());
		send_item(ACT_STATUS, tbl_mac[3], READY_CODE);
		send_item(ACT_KEEP, tbl_mac[3], KEEP_CODE);
		send_item(ACT_TICK, rand_mac(), $urandom());
		settle();
		write_cfg(32'd0, 1'b0);
		send_item(ACT_KEEP, tbl_mac[3], KEEP_CODE);
		send_item(ACT_TICK, rand_mac(), $urandom());
		settle();

		for (int s = 0; s < 8; s++) begin
			if (s == 3) begin
				snd_idle_pct = 73;
				rcv_idle_pct = 20;
			end
			if (s == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
				// drop every peer, then confirm all four so pairing closes
				write_cfg(32'd1, 1'b0);
				for (int k = 0; k < 4; k++)
					send_item(ACT_KEEP, tbl_mac[k], KEEP_CODE);
				send_item(ACT_TICK, rand_mac(), $urandom());
				for (int k = 0; k < 4; k++)
					send_item(ACT_STATUS, tbl_mac[k], READY_CODE);
				send_item(ACT_PAIR, spare_mac[1], $urandom());
				send_item(ACT_STATUS, tbl_mac[0], READY_CODE);
				settle();
			end
			for (int k = 0; k < 4; k++)
				spare_mac[k] = rand_mac();
			write_cfg(seg_tmo[s], seg_sd[s]);
			for (int n = 0; n < seg_len[s]; n++) begin
				if (s == 6 && n == 40)
					hold_req = 1'b1;
				random_item(s < 6);
			end
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** peer_liveness_table: PASSED **");
		else
			$display("** peer_liveness_table: FAILED **");
		$finish;
	end

endmodule
